// File: src/xmodem_checksum_receiver_unit_macros.svh
// Assertion macros used by the checker file of the XMODEM receiver.
`ifndef XMODEM_CHECKSUM_RECEIVER_UNIT_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define XCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define XCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/xcr_pkg.sv
// Shared types and constants of the XMODEM checksum receiver.
package xcr_pkg;

  localparam logic [7:0] BYTE_SOH = 8'h01;
  localparam logic [7:0] BYTE_EOT = 8'h04;
  localparam logic [7:0] BYTE_ACK = 8'h06;
  localparam logic [7:0] BYTE_NAK = 8'h15;

  localparam logic [31:0] BASE_RESET    = 32'd0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  JUNK_RESET    = 8'd10;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } xcr_func_t;

  typedef enum logic [1:0] {
    REG_BASE    = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_JUNK    = 2'd2
  } xcr_reg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } xcr_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic [31:0] write_address;
    logic [31:0] write_word;
    logic        finished;
    logic        last;
  } xcr_result_t;

  // Controller to datapath.
  typedef struct packed {
    logic attempt_clr;
    logic wp_load;
    logic tick_inc;
    logic junk_inc;
    logic frame_clr;
    logic frame_byte;
    logic word_clr;
    logic word_adv;
    logic rd_en;
    logic out_ctrl;
    logic out_nak;
    logic out_fin;
    logic out_word;
  } xcr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic soh;
    logic eot;
    logic junk_hit;
    logic tick_hit;
    logic frame_end;
    logic frame_good;
    logic word_last;
    logic slot_free;
  } xcr_stat_t;

endpackage

// File: src/xcr_if.sv
// Valid/ready channel interfaces for input items and result items.
interface xcr_item_if import xcr_pkg::*; ();
  logic      valid;
  logic      ready;
  xcr_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface xcr_result_if import xcr_pkg::*; ();
  logic        valid;
  logic        ready;
  xcr_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/xcr_datapath.sv
// Datapath: config registers, counters, frame buffer and result register.
module xcr_datapath import xcr_pkg::*; #(
  parameter int DATA_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [7:0]  rx_byte,
  input  xcr_cmd_t    cmd,
  output xcr_stat_t   stat,
  input  logic        out_ready,
  output logic        out_valid,
  output xcr_result_t out_data
);

  localparam int WORDS     = DATA_BYTES / 4;
  localparam int WORD_W    = $clog2(WORDS);
  localparam int FI_W      = $clog2(DATA_BYTES + 3);
  localparam int FRAME_END = DATA_BYTES + 2;

  logic [31:0]       base_address;
  logic [15:0]       timeout_ticks;
  logic [7:0]        max_junk;
  logic [FI_W-1:0]   frame_index;
  logic [7:0]        block_number;
  logic [7:0]        block_complement;
  logic [7:0]        running_sum;
  logic [15:0]       tick_count;
  logic [7:0]        junk_count;
  logic [31:0]       write_pointer;
  logic [31:0]       assembly;
  logic [31:0]       data_store [WORDS];
  logic [WORD_W-1:0] rd_idx;
  logic [31:0]       rd_data;

  logic [15:0]       tick_sum;
  logic [7:0]        junk_sum;
  logic [FI_W-1:0]   pos;
  logic [WORD_W-1:0] wr_idx;
  logic              data_pos;
  logic              word_done;

  assign tick_sum  = tick_count + 16'd1;
  assign junk_sum  = junk_count + 8'd1;
  assign pos       = frame_index - FI_W'(2);
  assign wr_idx    = pos[WORD_W+1:2];
  assign data_pos  = (frame_index >= FI_W'(2)) && (frame_index < FI_W'(FRAME_END));
  // fourth byte of a word: position mod 4 is three
  assign word_done = cmd.frame_byte && data_pos && (pos[1:0] == 2'b11);

  always_comb begin
    stat.soh        = (rx_byte == BYTE_SOH);
    stat.eot        = (rx_byte == BYTE_EOT);
    stat.junk_hit   = (junk_sum >= max_junk);
    stat.tick_hit   = (tick_sum >= timeout_ticks);
    stat.frame_end  = (frame_index == FI_W'(FRAME_END));
    stat.frame_good = (block_number == ~block_complement) && (rx_byte == running_sum);
    stat.word_last  = (rd_idx == WORD_W'(WORDS - 1));
    stat.slot_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= BASE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      max_junk      <= JUNK_RESET;
      frame_index   <= '0;
      running_sum   <= '0;
      tick_count    <= '0;
      junk_count    <= '0;
      write_pointer <= '0;
      rd_idx        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE:    base_address  <= cfg_data;
          REG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
          REG_JUNK:    max_junk      <= cfg_data[7:0];
          default:     ;
        endcase
      end

      if (cmd.attempt_clr) begin
        tick_count  <= '0;
        junk_count  <= '0;
        frame_index <= '0;
        running_sum <= '0;
      end else begin
        if (cmd.tick_inc) tick_count <= tick_sum;
        if (cmd.junk_inc) junk_count <= junk_sum;
        if (cmd.frame_clr) begin
          frame_index <= '0;
          running_sum <= '0;
        end else if (cmd.frame_byte) begin
          frame_index <= frame_index + FI_W'(1);
          if (data_pos) running_sum <= running_sum + rx_byte;
        end
      end

      if (cmd.wp_load) begin
        write_pointer <= base_address;
      end else if (cmd.out_word) begin
        write_pointer <= write_pointer + 32'd4;
      end

      if (cmd.word_clr) begin
        rd_idx <= '0;
      end else if (cmd.word_adv) begin
        rd_idx <= rd_idx + WORD_W'(1);
      end

      if (cmd.out_ctrl || cmd.out_word) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header bytes and word assembly.
  always_ff @(posedge clk) begin
    if (cmd.frame_byte) begin
      if (frame_index == FI_W'(0)) begin
        block_number <= rx_byte;
      end else if (frame_index == FI_W'(1)) begin
        block_complement <= rx_byte;
      end else if (data_pos) begin
        assembly <= {rx_byte, assembly[31:8]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_done) data_store[wr_idx] <= {rx_byte, assembly[31:8]};
    if (cmd.rd_en) rd_data <= data_store[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ctrl) begin
      out_data.kind          <= 1'b0;
      out_data.tx_byte       <= cmd.out_nak ? BYTE_NAK : BYTE_ACK;
      out_data.write_address <= '0;
      out_data.write_word    <= '0;
      out_data.finished      <= cmd.out_fin;
      out_data.last          <= 1'b1;
    end else if (cmd.out_word) begin
      out_data.kind          <= 1'b1;
      out_data.tx_byte       <= '0;
      out_data.write_address <= write_pointer;
      out_data.write_word    <= rd_data;
      out_data.finished      <= 1'b0;
      out_data.last          <= 1'b0;
    end
  end

endmodule

// File: src/xcr_controller.sv
// Controller: protocol phase and the word burst sequencer.
module xcr_controller import xcr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  xcr_stat_t  stat,
  output logic       in_ready,
  output xcr_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISCARD,
    S_WAIT,
    S_FRAME,
    S_DONE,
    S_READ,
    S_LOAD,
    S_ACK
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    case (state) inside
      S_READ, S_LOAD, S_ACK: in_ready = 1'b0;
      default:               in_ready = stat.slot_free;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (accept) begin
      unique case (func)
        FUNC_START: begin
          cmd.wp_load     = 1'b1;
          cmd.attempt_clr = 1'b1;
          cmd.out_ctrl    = 1'b1;
          cmd.out_nak     = 1'b1;
          state_next      = S_DISCARD;
        end
        FUNC_BYTE: begin
          case (state)
            S_DISCARD: begin
              cmd.attempt_clr = 1'b1;
              state_next      = S_WAIT;
            end
            S_WAIT: begin
              if (stat.soh) begin
                cmd.frame_clr = 1'b1;
                state_next    = S_FRAME;
              end else if (stat.eot) begin
                cmd.out_ctrl = 1'b1;
                cmd.out_fin  = 1'b1;
                state_next   = S_DONE;
              end else begin
                cmd.junk_inc = 1'b1;
                if (stat.junk_hit) begin
                  cmd.attempt_clr = 1'b1;
                  cmd.out_ctrl    = 1'b1;
                  cmd.out_nak     = 1'b1;
                end
              end
            end
            S_FRAME: begin
              if (stat.frame_end) begin
                cmd.attempt_clr = 1'b1;
                if (stat.frame_good) begin
                  cmd.word_clr = 1'b1;
                  state_next   = S_READ;
                end else begin
                  cmd.out_ctrl = 1'b1;
                  cmd.out_nak  = 1'b1;
                  state_next   = S_WAIT;
                end
              end else begin
                cmd.frame_byte = 1'b1;
              end
            end
            default: ;
          endcase
        end
        FUNC_TICK: begin
          case (state) inside
            S_DISCARD, S_WAIT, S_FRAME: begin
              cmd.tick_inc = 1'b1;
              if (stat.tick_hit) begin
                cmd.attempt_clr = 1'b1;
                state_next      = S_WAIT;
                // a timeout in the discard phase ends it silently
                if (state != S_DISCARD) begin
                  cmd.out_ctrl = 1'b1;
                  cmd.out_nak  = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end else begin
      case (state)
        S_READ: begin
          cmd.rd_en  = 1'b1;
          state_next = S_LOAD;
        end
        S_LOAD: begin
          if (stat.slot_free) begin
            cmd.out_word = 1'b1;
            cmd.word_adv = 1'b1;
            state_next   = stat.word_last ? S_ACK : S_READ;
          end
        end
        S_ACK: begin
          if (stat.slot_free) begin
            cmd.out_ctrl = 1'b1;
            state_next   = S_WAIT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/xmodem_checksum_receiver_unit.sv
// Top level of the XMODEM receiver with 8-bit checksum.
//
// Channels: items carries commands (start, received byte, tick) and results
// carries control bytes to transmit and data words to write; both move one
// transaction when valid and ready are high at a clock edge. Registers are
// written through cfg_we / cfg_index / cfg_data while the unit is idle;
// the user must keep to this, the unit does not enforce it. A NAK, or the
// ACK of an EOT, shows its result the cycle after its item is taken. Items
// are taken one per cycle, outside a word burst, while the result register
// is free or being drained in the same cycle. A good frame answers with
// DATA_BYTES/4 words and then an ACK; each word is a frame-buffer read and
// a result load, and no items are taken while the burst runs.
// A stalled receiver on results holds the current result and stops items
// and the burst until it is taken.
// Reset (rst, synchronous) restores the register defaults, leaves the unit
// idle until a start item, and empties the result register.
module xmodem_checksum_receiver_unit import xcr_pkg::*; #(
  parameter int DATA_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst,
  xcr_item_if.sink      items,
  xcr_result_if.source  results,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  xcr_cmd_t    cmd;
  xcr_stat_t   stat;
  logic        in_ready;
  logic        out_valid;
  xcr_result_t out_data;

  xcr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .func     (items.data.func),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  xcr_datapath #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (items.data.rx_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (results.ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign items.ready   = in_ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

endmodule

// File: src/xcr_checker.sv
// Port-level checker for the XMODEM receiver, bound to the top level.
`include "xmodem_checksum_receiver_unit_macros.svh"

module xcr_checker import xcr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        items_ready,
  input logic        results_valid,
  input logic        results_ready,
  input xcr_result_t results_data
);

  `XCR_ASSERT_NEXT(a_result_hold, results_valid && !results_ready, results_valid && $stable(results_data), "stalled result changed")
  `XCR_ASSERT_NOW(a_word_fields, results_valid && results_data.kind, results_data.tx_byte == 8'd0 && !results_data.finished && !results_data.last, "data word carries control fields")
  `XCR_ASSERT_NOW(a_ctrl_fields, results_valid && !results_data.kind, results_data.last && results_data.write_address == 32'd0 && results_data.write_word == 32'd0, "control byte malformed")
  `XCR_ASSERT_NOW(a_burst_blocks, results_valid && results_data.kind, !items_ready, "item taken during word burst")
  `XCR_ASSERT_NOW(a_finish_ack, results_valid && results_data.finished, results_data.tx_byte == BYTE_ACK, "finish without ACK")

endmodule

bind xmodem_checksum_receiver_unit xcr_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .items_ready   (items.ready),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .results_data  (results.data)
);
